FILE: sv/fla_pkg.sv
// Shared types, constants and sequencer command codes for the free list allocator.
// Used by the controller, the datapath and the top level; depends on nothing else.
package fla_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int ADDR_BITS  = 16;
  localparam int PID_BITS   = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int LEN_W      = ADDR_BITS + 1;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [PID_BITS-1:0]  pid_t;

  typedef struct packed {
    addr_t s;
    addr_t e;
  } free_rec_t;

  typedef struct packed {
    pid_t  o;
    addr_t s;
    addr_t e;
  } used_rec_t;

  localparam logic [1:0] OP_ALLOC    = 2'd0;
  localparam logic [1:0] OP_FREE     = 2'd1;
  localparam logic [1:0] OP_COALESCE = 2'd2;

  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_SIZE   = 1'b1;

  localparam logic [5:0] CMD_NONE    = 6'd0;
  localparam logic [5:0] CMD_LOAD    = 6'd1;
  localparam logic [5:0] CMD_SET_I1  = 6'd2;
  localparam logic [5:0] CMD_RD_FI   = 6'd3;
  localparam logic [5:0] CMD_CAP_F   = 6'd4;
  localparam logic [5:0] CMD_INC_I   = 6'd5;
  localparam logic [5:0] CMD_RD_FI1  = 6'd6;
  localparam logic [5:0] CMD_WR_FI   = 6'd7;
  localparam logic [5:0] CMD_R_DONE  = 6'd8;
  localparam logic [5:0] CMD_RD_UJ   = 6'd9;
  localparam logic [5:0] CMD_INC_J   = 6'd10;
  localparam logic [5:0] CMD_UI_HIT  = 6'd11;
  localparam logic [5:0] CMD_RD_UIM1 = 6'd12;
  localparam logic [5:0] CMD_WR_UI   = 6'd13;
  localparam logic [5:0] CMD_UI_PUT  = 6'd14;
  localparam logic [5:0] CMD_RD_FJ   = 6'd15;
  localparam logic [5:0] CMD_FI_HIT  = 6'd16;
  localparam logic [5:0] CMD_RD_FIM1 = 6'd17;
  localparam logic [5:0] CMD_WR_FIS  = 6'd18;
  localparam logic [5:0] CMD_FI_PUT  = 6'd19;
  localparam logic [5:0] CMD_RD_UI   = 6'd20;
  localparam logic [5:0] CMD_CAP_U   = 6'd21;
  localparam logic [5:0] CMD_RD_UI1  = 6'd22;
  localparam logic [5:0] CMD_WR_UIR  = 6'd23;
  localparam logic [5:0] CMD_UR_DONE = 6'd24;
  localparam logic [5:0] CMD_C_CAP   = 6'd25;
  localparam logic [5:0] CMD_RD_FJM1 = 6'd26;
  localparam logic [5:0] CMD_C_MOVE  = 6'd27;
  localparam logic [5:0] CMD_C_PUT   = 6'd28;
  localparam logic [5:0] CMD_M_INIT  = 6'd29;
  localparam logic [5:0] CMD_M_STEP  = 6'd30;
  localparam logic [5:0] CMD_M_END   = 6'd31;
  localparam logic [5:0] CMD_EMIT    = 6'd32;

  typedef struct packed {
    logic [5:0] op;
    logic       st_we;
    logic [1:0] st_val;
    logic       start_we;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       req_zero;
    logic       i_lt_flen;
    logic       i1_lt_flen;
    logic       i_lt_ulen;
    logic       i1_lt_ulen;
    logic       j_lt_flen;
    logic       j_lt_ulen;
    logic       i_gt_j;
    logic       j_nz;
    logic       fit;
    logic       owner_hit;
    logic       ulen_full;
    logic       flen_full;
    logic       uins_here;
    logic       fins_here;
    logic       sort_gt;
    logic       ne_ne_e;
    logic       out_busy;
  } sts_t;

endpackage

FILE: sv/fla_ram.sv
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// Stands alone; used for the free list and the allocated table.
module fla_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/fla_datapath.sv
// Datapath of the allocator: free list and allocated table memories, counts, loop indexes.
// Executes one command of fla_pkg per cycle and reports status flags; uses fla_ram.
module fla_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fla_pkg::cmd_t         cmd,
  output fla_pkg::sts_t         sts,
  input  logic [1:0]            in_operation,
  input  fla_pkg::pid_t         in_owner_id,
  input  fla_pkg::len_t         in_request_length,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  fla_pkg::len_t         cfg_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output fla_pkg::addr_t        out_block_start,
  output fla_pkg::cnt_t         out_free_count,
  output fla_pkg::cnt_t         out_alloc_count
);

  logic [1:0]        pol_r;
  fla_pkg::addr_t    end0_r;
  logic              init0_r;
  logic              rinit_r;
  fla_pkg::cnt_t     flen_r, ulen_r, i_r, j_r, w_r;
  logic [1:0]        op_r;
  fla_pkg::pid_t     pid_r;
  fla_pkg::len_t     req_r;
  fla_pkg::addr_t    s_r, e_r, ne_r, is_r, ie_r;
  logic [1:0]        st_r;
  fla_pkg::addr_t    start_r;
  logic              ovalid_r;
  logic [1:0]        ostat_r;
  fla_pkg::addr_t    ostart_r;
  fla_pkg::cnt_t     ofree_r, oalloc_r;

  fla_pkg::free_rec_t frd_raw, frd, fwd;
  fla_pkg::used_rec_t urd, uwd;
  fla_pkg::idx_t      fra, fwa, ura, uwa;
  logic               fwe, uwe;
  fla_pkg::cnt_t      i_p1, i_m1, j_m1, w_m1;
  fla_pkg::len_t      fspan, ispan, fsum;
  logic               adj;
  fla_pkg::addr_t     end0_nxt;

  fla_ram #(.W($bits(fla_pkg::free_rec_t)), .D(fla_pkg::MAX_BLOCKS)) u_free_ram (
    .clk(clk), .we(fwe), .waddr(fwa), .wdata(fwd), .raddr(fra), .rdata(frd_raw)
  );

  fla_ram #(.W($bits(fla_pkg::used_rec_t)), .D(fla_pkg::MAX_BLOCKS)) u_used_ram (
    .clk(clk), .we(uwe), .waddr(uwa), .wdata(uwd), .raddr(ura), .rdata(urd)
  );

  // Until entry 0 of the free list is written, it reads as the whole partition.
  always_comb begin
    frd = frd_raw;
    if (rinit_r) begin
      frd.s = '0;
      frd.e = end0_r;
    end
  end

  assign i_p1  = i_r + fla_pkg::cnt_t'(1);
  assign i_m1  = i_r - fla_pkg::cnt_t'(1);
  assign j_m1  = j_r - fla_pkg::cnt_t'(1);
  assign w_m1  = w_r - fla_pkg::cnt_t'(1);
  assign fspan = {1'b0, frd.e} - {1'b0, frd.s} + fla_pkg::len_t'(1);
  assign ispan = {1'b0, ie_r} - {1'b0, is_r} + fla_pkg::len_t'(1);
  assign fsum  = {1'b0, frd.s} + req_r;
  assign adj   = (w_r != '0) && (({1'b0, ie_r} + fla_pkg::len_t'(1)) == {1'b0, frd.s});

  always_comb begin
    if (cfg_data == '0) begin
      end0_nxt = '0;
    end else if (cfg_data[fla_pkg::ADDR_BITS]) begin
      end0_nxt = '1;
    end else begin
      end0_nxt = cfg_data[fla_pkg::ADDR_BITS-1:0] - fla_pkg::addr_t'(1);
    end
  end

  always_comb begin
    sts.op         = op_r;
    sts.req_zero   = (req_r == '0);
    sts.i_lt_flen  = (i_r < flen_r);
    sts.i1_lt_flen = (i_p1 < flen_r);
    sts.i_lt_ulen  = (i_r < ulen_r);
    sts.i1_lt_ulen = (i_p1 < ulen_r);
    sts.j_lt_flen  = (j_r < flen_r);
    sts.j_lt_ulen  = (j_r < ulen_r);
    sts.i_gt_j     = (i_r > j_r);
    sts.j_nz       = (j_r != '0);
    sts.fit        = (fspan >= req_r);
    sts.owner_hit  = (urd.o == pid_r);
    sts.ulen_full  = (ulen_r >= fla_pkg::cnt_t'(fla_pkg::MAX_BLOCKS));
    sts.flen_full  = (flen_r >= fla_pkg::cnt_t'(fla_pkg::MAX_BLOCKS));
    sts.uins_here  = (urd.s > s_r);
    sts.fins_here  = ((pol_r == fla_pkg::POL_BEST) && (fspan > ispan)) ||
                     ((pol_r == fla_pkg::POL_WORST) && (fspan < ispan));
    sts.sort_gt    = (frd.s > is_r);
    sts.ne_ne_e    = (ne_r != e_r);
    sts.out_busy   = ovalid_r && out_stall;
  end

  always_comb begin
    fra = '0;
    fwe = 1'b0;
    fwa = '0;
    fwd = frd;
    ura = '0;
    uwe = 1'b0;
    uwa = '0;
    uwd = urd;
    case (cmd.op)
      fla_pkg::CMD_RD_FI:   fra = i_r[fla_pkg::IDX_W-1:0];
      fla_pkg::CMD_RD_FI1:  fra = i_p1[fla_pkg::IDX_W-1:0];
      fla_pkg::CMD_RD_FJ:   fra = j_r[fla_pkg::IDX_W-1:0];
      fla_pkg::CMD_RD_FIM1: fra = i_m1[fla_pkg::IDX_W-1:0];
      fla_pkg::CMD_RD_FJM1: fra = j_m1[fla_pkg::IDX_W-1:0];
      fla_pkg::CMD_WR_FI, fla_pkg::CMD_WR_FIS: begin
        fwe = 1'b1;
        fwa = i_r[fla_pkg::IDX_W-1:0];
      end
      fla_pkg::CMD_C_MOVE: begin
        fwe = 1'b1;
        fwa = j_r[fla_pkg::IDX_W-1:0];
      end
      fla_pkg::CMD_FI_PUT, fla_pkg::CMD_C_PUT: begin
        fwe   = 1'b1;
        fwa   = j_r[fla_pkg::IDX_W-1:0];
        fwd.s = is_r;
        fwd.e = ie_r;
      end
      fla_pkg::CMD_M_STEP, fla_pkg::CMD_M_END: begin
        fwe   = (w_r != '0) && !((cmd.op == fla_pkg::CMD_M_STEP) && adj);
        fwa   = w_m1[fla_pkg::IDX_W-1:0];
        fwd.s = is_r;
        fwd.e = ie_r;
      end
      fla_pkg::CMD_RD_UJ:   ura = j_r[fla_pkg::IDX_W-1:0];
      fla_pkg::CMD_RD_UIM1: ura = i_m1[fla_pkg::IDX_W-1:0];
      fla_pkg::CMD_RD_UI:   ura = i_r[fla_pkg::IDX_W-1:0];
      fla_pkg::CMD_RD_UI1:  ura = i_p1[fla_pkg::IDX_W-1:0];
      fla_pkg::CMD_WR_UI, fla_pkg::CMD_WR_UIR: begin
        uwe = 1'b1;
        uwa = i_r[fla_pkg::IDX_W-1:0];
      end
      fla_pkg::CMD_UI_PUT: begin
        uwe   = 1'b1;
        uwa   = j_r[fla_pkg::IDX_W-1:0];
        uwd.o = pid_r;
        uwd.s = s_r;
        uwd.e = ne_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rinit_r <= (fra == '0) && init0_r;
    case (cmd.op)
      fla_pkg::CMD_LOAD: begin
        op_r  <= in_operation;
        pid_r <= in_owner_id;
        req_r <= in_request_length;
      end
      fla_pkg::CMD_CAP_F: begin
        s_r  <= frd.s;
        e_r  <= frd.e;
        ne_r <= fsum[fla_pkg::ADDR_BITS-1:0] - fla_pkg::addr_t'(1);
        is_r <= fsum[fla_pkg::ADDR_BITS-1:0];
        ie_r <= frd.e;
      end
      fla_pkg::CMD_CAP_U: begin
        s_r  <= urd.s;
        e_r  <= urd.e;
        is_r <= urd.s;
        ie_r <= urd.e;
      end
      fla_pkg::CMD_C_CAP: begin
        is_r <= frd.s;
        ie_r <= frd.e;
      end
      fla_pkg::CMD_M_STEP: begin
        if (adj) begin
          ie_r <= frd.e;
        end else begin
          is_r <= frd.s;
          ie_r <= frd.e;
        end
      end
      default: ;
    endcase
    if (cmd.op == fla_pkg::CMD_EMIT) begin
      ostat_r  <= st_r;
      ostart_r <= start_r;
      ofree_r  <= flen_r;
      oalloc_r <= ulen_r;
    end
    if (cmd.op == fla_pkg::CMD_LOAD) begin
      start_r <= '0;
    end else if (cmd.start_we) begin
      start_r <= s_r;
    end
    if (cmd.op == fla_pkg::CMD_LOAD) begin
      st_r <= fla_pkg::ST_OK;
    end else if (cmd.st_we) begin
      st_r <= cmd.st_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_r    <= '0;
      end0_r   <= '1;
      init0_r  <= 1'b1;
      flen_r   <= fla_pkg::cnt_t'(1);
      ulen_r   <= '0;
      i_r      <= '0;
      j_r      <= '0;
      w_r      <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.op == fla_pkg::CMD_EMIT) begin
        ovalid_r <= 1'b1;
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
      if (fwe && (fwa == '0)) begin
        init0_r <= 1'b0;
      end
      case (cmd.op)
        fla_pkg::CMD_LOAD: begin
          i_r <= '0;
          j_r <= '0;
        end
        fla_pkg::CMD_SET_I1:  i_r <= fla_pkg::cnt_t'(1);
        fla_pkg::CMD_INC_I:   i_r <= i_p1;
        fla_pkg::CMD_WR_FI:   i_r <= i_p1;
        fla_pkg::CMD_WR_UIR:  i_r <= i_p1;
        fla_pkg::CMD_R_DONE: begin
          flen_r <= flen_r - fla_pkg::cnt_t'(1);
          j_r    <= '0;
        end
        fla_pkg::CMD_UR_DONE: begin
          ulen_r <= ulen_r - fla_pkg::cnt_t'(1);
          j_r    <= '0;
        end
        fla_pkg::CMD_INC_J:   j_r <= j_r + fla_pkg::cnt_t'(1);
        fla_pkg::CMD_UI_HIT:  i_r <= ulen_r;
        fla_pkg::CMD_FI_HIT:  i_r <= flen_r;
        fla_pkg::CMD_WR_UI:   i_r <= i_m1;
        fla_pkg::CMD_WR_FIS:  i_r <= i_m1;
        fla_pkg::CMD_UI_PUT: begin
          ulen_r <= ulen_r + fla_pkg::cnt_t'(1);
          j_r    <= '0;
        end
        fla_pkg::CMD_FI_PUT:  flen_r <= flen_r + fla_pkg::cnt_t'(1);
        fla_pkg::CMD_C_CAP:   j_r <= i_r;
        fla_pkg::CMD_C_MOVE:  j_r <= j_m1;
        fla_pkg::CMD_C_PUT:   i_r <= i_p1;
        fla_pkg::CMD_M_INIT: begin
          i_r <= '0;
          w_r <= '0;
        end
        fla_pkg::CMD_M_STEP: begin
          i_r <= i_p1;
          if (!adj) begin
            w_r <= w_r + fla_pkg::cnt_t'(1);
          end
        end
        fla_pkg::CMD_M_END:   flen_r <= w_r;
        default: ;
      endcase
      if (cfg_we) begin
        if (cfg_index == fla_pkg::CFG_POLICY) begin
          pol_r <= cfg_data[1:0];
        end else begin
          end0_r  <= end0_nxt;
          init0_r <= 1'b1;
          flen_r  <= fla_pkg::cnt_t'(1);
          ulen_r  <= '0;
        end
      end
    end
  end

  assign out_valid       = ovalid_r;
  assign out_status      = ostat_r;
  assign out_block_start = ostart_r;
  assign out_free_count  = ofree_r;
  assign out_alloc_count = oalloc_r;

endmodule

FILE: sv/fla_controller.sv
// Sequencer of the allocator: walks the scan, shift, sort and merge loops one step a cycle.
// Drives fla_pkg commands into the datapath and reads back its status flags.
module fla_controller (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  fla_pkg::sts_t sts,
  output fla_pkg::cmd_t cmd
);

  localparam logic [5:0] S_IDLE     = 6'd0;
  localparam logic [5:0] S_DISP     = 6'd1;
  localparam logic [5:0] S_A_RD     = 6'd2;
  localparam logic [5:0] S_A_CHK    = 6'd3;
  localparam logic [5:0] S_A_FOUND  = 6'd4;
  localparam logic [5:0] S_R_RD     = 6'd5;
  localparam logic [5:0] S_R_WR     = 6'd6;
  localparam logic [5:0] S_UI_RD    = 6'd7;
  localparam logic [5:0] S_UI_CHK   = 6'd8;
  localparam logic [5:0] S_UI_SH_RD = 6'd9;
  localparam logic [5:0] S_UI_SH_WR = 6'd10;
  localparam logic [5:0] S_UI_PUT   = 6'd11;
  localparam logic [5:0] S_UI_NEXT  = 6'd12;
  localparam logic [5:0] S_FI_RD    = 6'd13;
  localparam logic [5:0] S_FI_CHK   = 6'd14;
  localparam logic [5:0] S_FI_SH_RD = 6'd15;
  localparam logic [5:0] S_FI_SH_WR = 6'd16;
  localparam logic [5:0] S_FI_PUT   = 6'd17;
  localparam logic [5:0] S_U_RD     = 6'd18;
  localparam logic [5:0] S_U_CHK    = 6'd19;
  localparam logic [5:0] S_U_FOUND  = 6'd20;
  localparam logic [5:0] S_UR_RD    = 6'd21;
  localparam logic [5:0] S_UR_WR    = 6'd22;
  localparam logic [5:0] S_C_RD     = 6'd23;
  localparam logic [5:0] S_C_CAP    = 6'd24;
  localparam logic [5:0] S_C_JRD    = 6'd25;
  localparam logic [5:0] S_C_JCHK   = 6'd26;
  localparam logic [5:0] S_C_PUT    = 6'd27;
  localparam logic [5:0] S_M_INIT   = 6'd28;
  localparam logic [5:0] S_M_RD     = 6'd29;
  localparam logic [5:0] S_M_CHK    = 6'd30;
  localparam logic [5:0] S_M_END    = 6'd31;
  localparam logic [5:0] S_FIN      = 6'd32;

  logic [5:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = fla_pkg::CMD_NONE;
    cmd.st_we    = 1'b0;
    cmd.st_val   = fla_pkg::ST_OK;
    cmd.start_we = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = fla_pkg::CMD_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          fla_pkg::OP_ALLOC: begin
            if (sts.req_zero) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = fla_pkg::ST_NOFIT;
              state_nxt  = S_FIN;
            end else begin
              state_nxt = S_A_RD;
            end
          end
          fla_pkg::OP_FREE: state_nxt = S_U_RD;
          fla_pkg::OP_COALESCE: begin
            cmd.op    = fla_pkg::CMD_SET_I1;
            state_nxt = S_C_RD;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_A_RD: begin
        if (sts.i_lt_flen) begin
          cmd.op    = fla_pkg::CMD_RD_FI;
          state_nxt = S_A_CHK;
        end else begin
          cmd.st_we  = 1'b1;
          cmd.st_val = fla_pkg::ST_NOFIT;
          state_nxt  = S_FIN;
        end
      end
      S_A_CHK: begin
        if (sts.fit) begin
          cmd.op    = fla_pkg::CMD_CAP_F;
          state_nxt = S_A_FOUND;
        end else begin
          cmd.op    = fla_pkg::CMD_INC_I;
          state_nxt = S_A_RD;
        end
      end
      S_A_FOUND: begin
        cmd.st_we = 1'b1;
        if (sts.ulen_full) begin
          cmd.st_val = fla_pkg::ST_FULL;
          state_nxt  = S_FIN;
        end else begin
          cmd.st_val   = fla_pkg::ST_OK;
          cmd.start_we = 1'b1;
          state_nxt    = S_R_RD;
        end
      end
      S_R_RD: begin
        if (sts.i1_lt_flen) begin
          cmd.op    = fla_pkg::CMD_RD_FI1;
          state_nxt = S_R_WR;
        end else begin
          cmd.op    = fla_pkg::CMD_R_DONE;
          state_nxt = S_UI_RD;
        end
      end
      S_R_WR: begin
        cmd.op    = fla_pkg::CMD_WR_FI;
        state_nxt = S_R_RD;
      end
      S_UI_RD: begin
        if (sts.j_lt_ulen) begin
          cmd.op    = fla_pkg::CMD_RD_UJ;
          state_nxt = S_UI_CHK;
        end else begin
          state_nxt = S_UI_PUT;
        end
      end
      S_UI_CHK: begin
        if (sts.uins_here) begin
          cmd.op    = fla_pkg::CMD_UI_HIT;
          state_nxt = S_UI_SH_RD;
        end else begin
          cmd.op    = fla_pkg::CMD_INC_J;
          state_nxt = S_UI_RD;
        end
      end
      S_UI_SH_RD: begin
        if (sts.i_gt_j) begin
          cmd.op    = fla_pkg::CMD_RD_UIM1;
          state_nxt = S_UI_SH_WR;
        end else begin
          state_nxt = S_UI_PUT;
        end
      end
      S_UI_SH_WR: begin
        cmd.op    = fla_pkg::CMD_WR_UI;
        state_nxt = S_UI_SH_RD;
      end
      S_UI_PUT: begin
        cmd.op    = fla_pkg::CMD_UI_PUT;
        state_nxt = S_UI_NEXT;
      end
      S_UI_NEXT: state_nxt = sts.ne_ne_e ? S_FI_RD : S_FIN;
      S_FI_RD: begin
        if (sts.j_lt_flen) begin
          cmd.op    = fla_pkg::CMD_RD_FJ;
          state_nxt = S_FI_CHK;
        end else begin
          state_nxt = S_FI_PUT;
        end
      end
      S_FI_CHK: begin
        if (sts.fins_here) begin
          cmd.op    = fla_pkg::CMD_FI_HIT;
          state_nxt = S_FI_SH_RD;
        end else begin
          cmd.op    = fla_pkg::CMD_INC_J;
          state_nxt = S_FI_RD;
        end
      end
      S_FI_SH_RD: begin
        if (sts.i_gt_j) begin
          cmd.op    = fla_pkg::CMD_RD_FIM1;
          state_nxt = S_FI_SH_WR;
        end else begin
          state_nxt = S_FI_PUT;
        end
      end
      S_FI_SH_WR: begin
        cmd.op    = fla_pkg::CMD_WR_FIS;
        state_nxt = S_FI_SH_RD;
      end
      S_FI_PUT: begin
        cmd.op    = fla_pkg::CMD_FI_PUT;
        state_nxt = S_FIN;
      end
      S_U_RD: begin
        if (sts.i_lt_ulen) begin
          cmd.op    = fla_pkg::CMD_RD_UI;
          state_nxt = S_U_CHK;
        end else begin
          cmd.st_we  = 1'b1;
          cmd.st_val = fla_pkg::ST_NOTFOUND;
          state_nxt  = S_FIN;
        end
      end
      S_U_CHK: begin
        if (sts.owner_hit) begin
          cmd.op    = fla_pkg::CMD_CAP_U;
          state_nxt = S_U_FOUND;
        end else begin
          cmd.op    = fla_pkg::CMD_INC_I;
          state_nxt = S_U_RD;
        end
      end
      S_U_FOUND: begin
        cmd.st_we = 1'b1;
        if (sts.flen_full) begin
          cmd.st_val = fla_pkg::ST_FULL;
          state_nxt  = S_FIN;
        end else begin
          cmd.st_val   = fla_pkg::ST_OK;
          cmd.start_we = 1'b1;
          state_nxt    = S_UR_RD;
        end
      end
      S_UR_RD: begin
        if (sts.i1_lt_ulen) begin
          cmd.op    = fla_pkg::CMD_RD_UI1;
          state_nxt = S_UR_WR;
        end else begin
          cmd.op    = fla_pkg::CMD_UR_DONE;
          state_nxt = S_FI_RD;
        end
      end
      S_UR_WR: begin
        cmd.op    = fla_pkg::CMD_WR_UIR;
        state_nxt = S_UR_RD;
      end
      S_C_RD: begin
        if (sts.i_lt_flen) begin
          cmd.op    = fla_pkg::CMD_RD_FI;
          state_nxt = S_C_CAP;
        end else begin
          state_nxt = S_M_INIT;
        end
      end
      S_C_CAP: begin
        cmd.op    = fla_pkg::CMD_C_CAP;
        state_nxt = S_C_JRD;
      end
      S_C_JRD: begin
        if (sts.j_nz) begin
          cmd.op    = fla_pkg::CMD_RD_FJM1;
          state_nxt = S_C_JCHK;
        end else begin
          state_nxt = S_C_PUT;
        end
      end
      S_C_JCHK: begin
        if (sts.sort_gt) begin
          cmd.op    = fla_pkg::CMD_C_MOVE;
          state_nxt = S_C_JRD;
        end else begin
          state_nxt = S_C_PUT;
        end
      end
      S_C_PUT: begin
        cmd.op    = fla_pkg::CMD_C_PUT;
        state_nxt = S_C_RD;
      end
      S_M_INIT: begin
        cmd.op    = fla_pkg::CMD_M_INIT;
        state_nxt = S_M_RD;
      end
      S_M_RD: begin
        if (sts.i_lt_flen) begin
          cmd.op    = fla_pkg::CMD_RD_FI;
          state_nxt = S_M_CHK;
        end else begin
          state_nxt = S_M_END;
        end
      end
      S_M_CHK: begin
        cmd.op    = fla_pkg::CMD_M_STEP;
        state_nxt = S_M_RD;
      end
      S_M_END: begin
        cmd.op    = fla_pkg::CMD_M_END;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.op    = fla_pkg::CMD_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/free_list_block_allocator.sv
// Top level of the free list block allocator: controller plus datapath.
// Depends on fla_pkg, fla_controller, fla_datapath and fla_ram.
//
// One request is handled at a time; every table step reads the single read port of the
// free list or allocated table memory in a read state and uses the registered data in the
// check or write state that follows. An allocate scans and shifts the free list, then
// inserts into the allocated table and, when a remainder is left, into the free list. A
// free scans and shifts the allocated table, then inserts into the free list. A coalesce
// runs an insertion sort over the free list, then a merge pass. There is no clearing
// pass: entry 0 of the free list reads as the whole partition after reset or a partition
// size write until it is overwritten. The result waits in an output register, and
// the next request is taken while it waits.
module free_list_block_allocator (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_operation,
  input  fla_pkg::pid_t         in_owner_id,
  input  fla_pkg::len_t         in_request_length,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output fla_pkg::addr_t        out_block_start,
  output fla_pkg::cnt_t         out_free_count,
  output fla_pkg::cnt_t         out_alloc_count,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  fla_pkg::len_t         cfg_data
);

  fla_pkg::cmd_t cmd;
  fla_pkg::sts_t sts;

  fla_controller u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  fla_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_operation(in_operation), .in_owner_id(in_owner_id),
    .in_request_length(in_request_length),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_block_start(out_block_start), .out_free_count(out_free_count),
    .out_alloc_count(out_alloc_count)
  );

endmodule
